@@ rtl/core/crdt_pkg.sv @@
// Shared types and constants for the circular receive DMA drain tracker.
package crdt_pkg;

  localparam int unsigned BUF_SIZE = 512;
  localparam int unsigned OFF_W    = $clog2(BUF_SIZE);
  localparam int unsigned LEN_W    = OFF_W + 1;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned FREE_W   = 16;
  localparam int unsigned THR_W    = 16;

  localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUF_SIZE);
  localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(BUF_SIZE);
  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(BUF_SIZE / 2);
  localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    CMD_HALF = 2'd0,
    CMD_WRAP = 2'd1,
    CMD_POLL = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic half;
    logic wrap;
    logic stop;
    logic load;
    logic upd;
    logic ovr;
    logic emit;
    logic second;
  } ctrl_cmd_t;

  typedef struct packed {
    logic avail;
    logic last;
  } dp_stat_t;

endpackage

@@ rtl/core/crdt_dp.sv @@
// Datapath: ring counters, idle timer, config register and chunk output registers.
module crdt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crdt_pkg::ctrl_cmd_t                 cmd,
  output crdt_pkg::dp_stat_t                  stat,
  input  logic [crdt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                thr_we,
  input  logic [crdt_pkg::THR_W-1:0]          thr_wdata,
  output logic [crdt_pkg::THR_W-1:0]          thr_q,
  output logic [crdt_pkg::OFF_W-1:0]          chunk_offset,
  output logic [crdt_pkg::LEN_W-1:0]          chunk_length,
  output logic                                chunk_last,
  output logic                                overrun
);

  localparam int unsigned OFF_W = crdt_pkg::OFF_W;
  localparam int unsigned LEN_W = crdt_pkg::LEN_W;
  localparam int unsigned CNT_W = crdt_pkg::CNT_W;
  localparam int unsigned TIME_W = crdt_pkg::TIME_W;
  localparam int unsigned FREE_W = crdt_pkg::FREE_W;

  logic [crdt_pkg::THR_W-1:0] thr_r;
  logic [CNT_W-1:0]  wrap_r, head_r, read_r;
  logic [LEN_W-1:0]  last_rem_r, p_rem_r;
  logic [TIME_W-1:0] last_time_r, p_now_r;
  logic [FREE_W-1:0] free_r;
  logic              ovr_r;
  logic [OFF_W-1:0]  off_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;

  logic [LEN_W-1:0]  in_rem, rem_clamp;
  logic [TIME_W-1:0] in_now, elapsed;
  logic [FREE_W-1:0] in_free;
  logic [OFF_W-1:0]  pos;
  logic [CNT_W-1:0]  idle_a, idle_b, diff;
  logic              idle_go, commit;
  logic [OFF_W-1:0]  c_off;
  logic [LEN_W-1:0]  contig, len_a, c_len;
  logic              c_last;

  assign in_rem  = in_tdata[LEN_W-1:0];
  assign in_now  = in_tdata[LEN_W +: TIME_W];
  assign in_free = in_tdata[LEN_W+TIME_W +: FREE_W];
  assign rem_clamp = (in_rem > crdt_pkg::BUF_LEN) ? crdt_pkg::BUF_LEN : in_rem;

  // idle flush candidate
  assign elapsed = p_now_r - last_time_r;
  assign idle_go = (elapsed >= thr_r) && (p_rem_r != crdt_pkg::BUF_LEN);
  assign pos     = -p_rem_r[OFF_W-1:0];
  assign idle_a  = {wrap_r[CNT_W-OFF_W-1:0], pos};
  assign idle_b  = idle_a + crdt_pkg::BUF_CNT;
  assign commit  = (idle_a < head_r) ? (idle_b > head_r) : (idle_a > head_r);

  // chunk sizing
  assign diff   = head_r - read_r;
  assign c_off  = read_r[OFF_W-1:0];
  assign contig = crdt_pkg::BUF_LEN - LEN_W'(c_off);
  assign len_a  = (diff > CNT_W'(contig)) ? contig : diff[LEN_W-1:0];
  assign c_len  = (FREE_W'(len_a) > free_r) ? free_r[LEN_W-1:0] : len_a;
  assign c_last = cmd.second || (CNT_W'(c_len) == diff) || (FREE_W'(c_len) == free_r);

  assign stat.avail = (head_r != read_r) && (free_r != '0);
  assign stat.last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= crdt_pkg::THR_RESET;
      wrap_r      <= '0;
      head_r      <= '0;
      read_r      <= '0;
      last_rem_r  <= crdt_pkg::BUF_LEN;
      last_time_r <= '0;
    end else begin
      if (thr_we) begin
        thr_r <= thr_wdata;
      end
      if (cmd.half) begin
        head_r <= {wrap_r[CNT_W-OFF_W-1:0], {OFF_W{1'b0}}} + crdt_pkg::HALF_CNT;
      end
      if (cmd.wrap) begin
        wrap_r <= wrap_r + CNT_W'(1);
        head_r <= {wrap_r[CNT_W-OFF_W-1:0] + (CNT_W-OFF_W)'(1), {OFF_W{1'b0}}};
      end
      if (cmd.stop) begin
        wrap_r      <= '0;
        head_r      <= '0;
        read_r      <= '0;
        last_rem_r  <= crdt_pkg::BUF_LEN;
        last_time_r <= in_now;
      end
      if (cmd.upd) begin
        if (p_rem_r != last_rem_r) begin
          last_rem_r  <= p_rem_r;
          last_time_r <= p_now_r;
        end else if (idle_go && commit) begin
          head_r <= (idle_a < head_r) ? idle_b : idle_a;
        end
      end
      if (cmd.ovr && (diff > crdt_pkg::BUF_CNT)) begin
        read_r <= head_r - crdt_pkg::BUF_CNT;
      end
      if (cmd.emit) begin
        read_r <= read_r + CNT_W'(c_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_rem_r <= rem_clamp;
      p_now_r <= in_now;
      free_r  <= in_free;
      ovr_r   <= 1'b0;
    end
    if (cmd.ovr && (diff > crdt_pkg::BUF_CNT)) begin
      ovr_r <= 1'b1;
    end
    if (cmd.emit) begin
      free_r <= free_r - FREE_W'(c_len);
      off_r  <= c_off;
      len_r  <= c_len;
      last_r <= c_last;
    end
  end

  assign thr_q        = thr_r;
  assign chunk_offset = off_r;
  assign chunk_length = len_r;
  assign chunk_last   = last_r;
  assign overrun      = ovr_r;

endmodule

@@ rtl/core/crdt_ctrl.sv @@
// Controller: sequences events, poll update, overrun check and chunk emission.
module crdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output crdt_pkg::ctrl_cmd_t  cmd,
  input  crdt_pkg::dp_stat_t   stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_OVR,
    S_CHUNK,
    S_WAIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   second_r;
  logic   in_acc;
  crdt_pkg::cmd_t in_cmd;

  assign in_cmd    = crdt_pkg::cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.half   = in_acc && (in_cmd == crdt_pkg::CMD_HALF);
    cmd.wrap   = in_acc && (in_cmd == crdt_pkg::CMD_WRAP);
    cmd.load   = in_acc && (in_cmd == crdt_pkg::CMD_POLL);
    cmd.stop   = in_acc && (in_cmd == crdt_pkg::CMD_STOP);
    cmd.upd    = (state_r == S_UPD);
    cmd.ovr    = (state_r == S_OVR);
    cmd.emit   = (state_r == S_CHUNK) && stat.avail;
    cmd.second = second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          second_r <= 1'b0;
          if (in_acc && (in_cmd == crdt_pkg::CMD_POLL)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= S_OVR;
        end
        S_OVR: begin
          state_r <= S_CHUNK;
        end
        S_CHUNK: begin
          if (stat.avail) begin
            out_valid_r <= 1'b1;
            state_r     <= S_WAIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (stat.last) begin
              state_r <= S_IDLE;
            end else begin
              second_r <= 1'b1;
              state_r  <= S_CHUNK;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_WAIT))
    else $error("output word valid outside wait state");

  a_emit_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHUNK) && stat.avail |=> out_valid_r)
    else $error("chunk computed but not presented");

  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && second_r |-> stat.last)
    else $error("second chunk of a poll not marked last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready)
    else $error("input accepted while chunk pending");

endmodule

@@ rtl/core/circular_rx_dma_drain_tracker_core.sv @@
// Top level of the circular receive DMA drain tracker: ports, config port, submodules.
//
// Half-transfer, wrap and stop words are accepted in the idle state. A poll word
// passes through capture, idle-flush update and overrun check before the first
// chunk is sized; each chunk is then sized and waits on out_tready. A poll yields
// no chunk, one or two. The input is not accepted again until the poll's last
// chunk has been taken; the sequencer in crdt_ctrl enforces this. A chunk never
// crosses the buffer wrap point and never exceeds the downstream free space given
// with the poll; the overrun flag marks chunks of a poll that skipped unread bytes.
module circular_rx_dma_drain_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // dma_remaining[9:0], time_now[25:10], sink_free[41:26]
  input  logic [1:0]  in_tuser,  // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // chunk_offset[8:0], chunk_length[18:9]
  output logic        out_tlast,
  output logic [0:0]  out_tuser, // overrun[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned OFF_W = crdt_pkg::OFF_W;
  localparam int unsigned LEN_W = crdt_pkg::LEN_W;
  localparam int unsigned THR_W = crdt_pkg::THR_W;

  crdt_pkg::ctrl_cmd_t cmd;
  crdt_pkg::dp_stat_t  stat;
  logic                thr_we;
  logic [THR_W-1:0]    thr_q;
  logic [OFF_W-1:0]    chunk_offset;
  logic [LEN_W-1:0]    chunk_length;
  logic                chunk_last;
  logic                overrun;

  assign cfg_pready = 1'b1;
  assign thr_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(thr_q);

  crdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  crdt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_tdata     (in_tdata),
    .thr_we       (thr_we),
    .thr_wdata    (cfg_pwdata[THR_W-1:0]),
    .thr_q        (thr_q),
    .chunk_offset (chunk_offset),
    .chunk_length (chunk_length),
    .chunk_last   (chunk_last),
    .overrun      (overrun)
  );

  assign out_tdata = {5'd0, chunk_length, chunk_offset};
  assign out_tlast = chunk_last;
  assign out_tuser = overrun;

endmodule
